/* rtl/core/cfar_frame_detector_unit_macros.svh */
// Assertion macros used by the CFAR frame detector checker.
`ifndef CFAR_FRAME_DETECTOR_UNIT_MACROS_SVH
`define CFAR_FRAME_DETECTOR_UNIT_MACROS_SVH

// Clocked assertion, off while reset is asserted.
`define CFD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked assertion, also checked while reset is asserted.
`define CFD_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

/* rtl/core/cfd_pkg.sv */
// Package with constants, register indexes and state type of the CFAR frame detector.
package cfd_pkg;

  localparam int unsigned MAX_CELLS_DEF = 1024;
  localparam int unsigned MAX_REF_DEF   = 32;

  localparam int unsigned SAMPLE_W     = 16;
  localparam int unsigned CELL_INDEX_W = 10;
  localparam int unsigned LEVEL_W      = 23;
  localparam int unsigned SCALE_W      = 16;
  localparam int unsigned CFG_W        = 16;
  localparam int unsigned CFG_IDX_W    = 3;
  localparam int unsigned LEVEL_MAX    = 8388607;

  localparam logic [CFG_IDX_W-1:0] REG_CFAR_MODE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DET_MODE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CELL_COUNT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REF_CELLS  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GUARD      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RANK       = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE      = 3'd6;

  localparam logic [2:0] MODE_CA = 3'd0;
  localparam logic [2:0] MODE_SO = 3'd1;
  localparam logic [2:0] MODE_GO = 3'd2;
  localparam logic [2:0] MODE_OS = 3'd3;

  localparam logic [1:0] DET_ENVELOPE = 2'd0;
  localparam logic [1:0] DET_SQUARE   = 2'd1;
  localparam logic [1:0] DET_LINEAR   = 2'd2;
  localparam logic [1:0] DET_LOG      = 2'd3;

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_EMIT = 1'b1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LEAD,
    ST_LAG,
    ST_CUT,
    ST_SMP,
    ST_DIV,
    ST_LEVEL,
    ST_MUL,
    ST_FIN
  } cfd_state_e;

endpackage

/* rtl/core/cfar_frame_detector_unit.sv */
// CFAR frame detector: frame memory, window walk, ranking, averaging and threshold.
//
// Usage: configuration registers are written through cfg_we_i/cfg_index_i/cfg_data_i
// while the block is idle. Items enter on in_valid_i/in_stall_o: action 0 stores
// sample_i in the frame memory at the next load position and gives no result; action 1
// computes the result of the next cell, delivered on out_valid_o/out_stall_i.
// An emit walks the leading then the lagging window through the read port of the
// frame memory, one cell per cycle, then divides both window sums by R with a
// bit-serial divider that works through the SUM_W bits of each sum (SUM_W = 23
// at default parameters), then scales. The block takes no new item until the
// emit's result is loaded into the output register; a load stays in the idle
// state, so the next item can follow it directly.
// After reset all MAX_CELLS entries of the frame memory are cleared, one entry per
// cycle; in_stall_o stays high meanwhile. The result sits in an output
// register: loads are still taken while it waits, and an emit finishes its
// work and holds in its last step until the receiver stops stalling.
module cfar_frame_detector_unit #(
  parameter int unsigned MAX_CELLS     = cfd_pkg::MAX_CELLS_DEF,
  parameter int unsigned MAX_REFERENCE = cfd_pkg::MAX_REF_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [cfd_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [cfd_pkg::CFG_W-1:0]             cfg_data_i,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic                                  action_i,
  input  logic signed [cfd_pkg::SAMPLE_W-1:0]   sample_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic [cfd_pkg::CELL_INDEX_W-1:0]      cell_index_o,
  output logic signed [cfd_pkg::SAMPLE_W-1:0]   detection_o,
  output logic [cfd_pkg::LEVEL_W-1:0]           threshold_level_o,
  output logic                                  last_cell_o
);

  localparam int unsigned IDX_W  = $clog2(MAX_CELLS);
  localparam int unsigned CNT_W  = $clog2(MAX_CELLS + 1);
  localparam int unsigned CMP_W  = (CNT_W > 11) ? CNT_W : 11;
  localparam int unsigned RW     = $clog2(MAX_REFERENCE + 1);
  localparam int unsigned RC_W   = (RW > 6) ? RW : 6;
  localparam int unsigned SORT_N = 2 * MAX_REFERENCE;
  localparam int unsigned SORT_W = $clog2(SORT_N);
  localparam int unsigned KC_W   = (RW + 2 > 7) ? RW + 2 : 7;
  localparam int unsigned VAL_W  = cfd_pkg::SAMPLE_W + 1;
  localparam int unsigned SUM_W  = VAL_W + $clog2(MAX_REFERENCE) + 1;
  localparam int unsigned SP_W   = $clog2(16 + MAX_REFERENCE);
  localparam int unsigned DC_W   = $clog2(SUM_W + 1);
  localparam int unsigned PROD_W = cfd_pkg::SCALE_W + 1 + VAL_W;
  localparam int unsigned THR_W  = PROD_W - 8;

  // configuration
  logic [2:0]                     mode_q;
  logic [1:0]                     det_q;
  logic [10:0]                    cc_q;
  logic [5:0]                     ref_q;
  logic [3:0]                     guard_q;
  logic [6:0]                     rank_q;
  logic [cfd_pkg::SCALE_W-1:0]    scale_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= cfd_pkg::MODE_CA;
      det_q   <= cfd_pkg::DET_SQUARE;
      cc_q    <= 11'd1000;
      ref_q   <= 6'd32;
      guard_q <= 4'd4;
      rank_q  <= 7'd24;
      scale_q <= 16'd3584;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        cfd_pkg::REG_CFAR_MODE:  mode_q  <= cfg_data_i[2:0];
        cfd_pkg::REG_DET_MODE:   det_q   <= cfg_data_i[1:0];
        cfd_pkg::REG_CELL_COUNT: cc_q    <= cfg_data_i[10:0];
        cfd_pkg::REG_REF_CELLS:  ref_q   <= cfg_data_i[5:0];
        cfd_pkg::REG_GUARD:      guard_q <= cfg_data_i[3:0];
        cfd_pkg::REG_RANK:       rank_q  <= cfg_data_i[6:0];
        cfd_pkg::REG_SCALE:      scale_q <= cfg_data_i[cfd_pkg::SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  logic [CNT_W-1:0] c_eff;
  logic [IDX_W-1:0] c_last;
  logic [RW-1:0]    r_eff;
  logic [SP_W-1:0]  span;

  always_comb begin
    if (cc_q == '0) begin
      c_eff = CNT_W'(1);
    end else if (CMP_W'(cc_q) > CMP_W'(MAX_CELLS)) begin
      c_eff = CNT_W'(MAX_CELLS);
    end else begin
      c_eff = CNT_W'(cc_q);
    end
    c_last = IDX_W'(c_eff - CNT_W'(1));
    if (ref_q == '0) begin
      r_eff = RW'(1);
    end else if (RC_W'(ref_q) > RC_W'(MAX_REFERENCE)) begin
      r_eff = RW'(MAX_REFERENCE);
    end else begin
      r_eff = RW'(ref_q);
    end
    span = SP_W'(guard_q) + SP_W'(r_eff);
  end

  // frame memory
  logic [cfd_pkg::SAMPLE_W-1:0] mem_q [MAX_CELLS];
  logic [cfd_pkg::SAMPLE_W-1:0] mem_rd_q;
  logic                         mem_we;
  logic [IDX_W-1:0]             mem_wa;
  logic [cfd_pkg::SAMPLE_W-1:0] mem_wd;
  logic [IDX_W-1:0]             rd_addr;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
  end

  always_ff @(posedge clk_i) begin
    mem_rd_q <= mem_q[rd_addr];
  end

  // control
  cfd_pkg::cfd_state_e state_q, state_d;
  logic [IDX_W-1:0] p_q, p_d, p_nx, cut_q, cut_d, lp_q, lp_d, ep_q, ep_d, clr_q, clr_d;
  logic [IDX_W-1:0] lp_use, ep_use;
  logic [SP_W-1:0]  s_q, s_d;
  logic [DC_W-1:0]  dc_q, dc_d;
  logic             take_q, take_d, side_q, side_d;
  logic             start, div_load, div_step, out_load;
  logic             out_valid_q;

  assign lp_use = (CNT_W'(lp_q) >= c_eff) ? '0 : lp_q;
  assign ep_use = (CNT_W'(ep_q) >= c_eff) ? '0 : ep_q;

  always_comb begin
    state_d    = state_q;
    p_d        = p_q;
    p_nx       = p_q;
    s_d        = s_q;
    cut_d      = cut_q;
    lp_d       = lp_q;
    ep_d       = ep_q;
    clr_d      = clr_q;
    dc_d       = dc_q;
    take_d     = 1'b0;
    side_d     = side_q;
    rd_addr    = p_q;
    mem_we     = 1'b0;
    mem_wa     = lp_use;
    mem_wd     = sample_i;
    in_stall_o = 1'b1;
    start      = 1'b0;
    div_load   = 1'b0;
    div_step   = 1'b0;
    out_load   = 1'b0;
    case (state_q)
      cfd_pkg::ST_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_q;
        mem_wd = '0;
        clr_d  = clr_q + IDX_W'(1);
        if (clr_q == IDX_W'(MAX_CELLS - 1)) begin
          state_d = cfd_pkg::ST_IDLE;
        end
      end
      cfd_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          if (action_i == cfd_pkg::ACT_LOAD) begin
            mem_we = 1'b1;
            lp_d   = (CNT_W'(lp_use) + CNT_W'(1) >= c_eff) ? '0 : lp_use + IDX_W'(1);
          end else begin
            start   = 1'b1;
            cut_d   = ep_use;
            p_d     = ep_use;
            s_d     = '0;
            state_d = cfd_pkg::ST_LEAD;
          end
        end
      end
      cfd_pkg::ST_LEAD: begin
        p_nx    = (p_q == '0) ? c_last : p_q - IDX_W'(1);
        p_d     = p_nx;
        rd_addr = p_nx;
        s_d     = s_q + SP_W'(1);
        take_d  = s_d > SP_W'(guard_q);
        side_d  = 1'b0;
        if (s_d == span) begin
          p_d     = cut_q;
          s_d     = '0;
          state_d = cfd_pkg::ST_LAG;
        end
      end
      cfd_pkg::ST_LAG: begin
        p_nx    = (CNT_W'(p_q) + CNT_W'(1) >= c_eff) ? '0 : p_q + IDX_W'(1);
        p_d     = p_nx;
        rd_addr = p_nx;
        s_d     = s_q + SP_W'(1);
        take_d  = s_d > SP_W'(guard_q);
        side_d  = 1'b1;
        if (s_d == span) begin
          state_d = cfd_pkg::ST_CUT;
        end
      end
      cfd_pkg::ST_CUT: begin
        rd_addr = cut_q;
        state_d = cfd_pkg::ST_SMP;
      end
      cfd_pkg::ST_SMP: begin
        div_load = 1'b1;
        dc_d     = '0;
        state_d  = cfd_pkg::ST_DIV;
      end
      cfd_pkg::ST_DIV: begin
        div_step = 1'b1;
        dc_d     = dc_q + DC_W'(1);
        if (dc_q == DC_W'(SUM_W - 1)) begin
          state_d = cfd_pkg::ST_LEVEL;
        end
      end
      cfd_pkg::ST_LEVEL: state_d = cfd_pkg::ST_MUL;
      cfd_pkg::ST_MUL:   state_d = cfd_pkg::ST_FIN;
      cfd_pkg::ST_FIN: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          ep_d     = (cut_q == c_last) ? '0 : cut_q + IDX_W'(1);
          state_d  = cfd_pkg::ST_IDLE;
        end
      end
      default: state_d = cfd_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cfd_pkg::ST_CLEAR;
      p_q     <= '0;
      s_q     <= '0;
      cut_q   <= '0;
      lp_q    <= '0;
      ep_q    <= '0;
      clr_q   <= '0;
      dc_q    <= '0;
      take_q  <= 1'b0;
      side_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      p_q     <= p_d;
      s_q     <= s_d;
      cut_q   <= cut_d;
      lp_q    <= lp_d;
      ep_q    <= ep_d;
      clr_q   <= clr_d;
      dc_q    <= dc_d;
      take_q  <= take_d;
      side_q  <= side_d;
    end
  end

  // window cell value, sums and ranking
  logic signed [VAL_W-1:0] rd_s, cell_v;
  logic signed [VAL_W-1:0] sorted_q [SORT_N];
  logic signed [VAL_W-1:0] ins_v    [SORT_N];
  logic [SORT_N-1:0]       keep;
  logic [SORT_W:0]         cnt_q;
  logic signed [SUM_W-1:0] sum_q [2];

  assign rd_s = $signed({mem_rd_q[cfd_pkg::SAMPLE_W-1], mem_rd_q});

  always_comb begin
    if ((det_q inside {cfd_pkg::DET_ENVELOPE, cfd_pkg::DET_SQUARE}) && rd_s < 0) begin
      cell_v = -rd_s;
    end else begin
      cell_v = rd_s;
    end
    for (int j = 0; j < SORT_N; j++) begin
      keep[j] = ((SORT_W + 1)'(j) < cnt_q) && (sorted_q[j] <= cell_v);
    end
    for (int j = 0; j < SORT_N; j++) begin
      if (keep[j]) begin
        ins_v[j] = sorted_q[j];
      end else if (j > 0 && !keep[(j > 0) ? j - 1 : 0]) begin
        ins_v[j] = sorted_q[(j > 0) ? j - 1 : 0];
      end else begin
        ins_v[j] = cell_v;
      end
    end
  end

  // divider lanes
  logic                    neg_q [2];
  logic [SUM_W-1:0]        dq_q  [2];
  logic [RW-1:0]           rem_q [2];
  logic [RW:0]             trial [2];
  logic                    ge    [2];
  logic signed [SUM_W-1:0] avg_w [2];
  logic signed [VAL_W-1:0] avg   [2];

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      trial[l] = {rem_q[l], dq_q[l][SUM_W-1]};
      ge[l]    = trial[l] >= (RW + 1)'(r_eff);
      if (neg_q[l]) begin
        avg_w[l] = -$signed(dq_q[l]) - ((rem_q[l] != '0) ? SUM_W'(1) : SUM_W'(0));
      end else begin
        avg_w[l] = $signed(dq_q[l]);
      end
      avg[l] = VAL_W'(avg_w[l]);
    end
  end

  // noise level
  logic signed [VAL_W:0]   ca_sum;
  logic signed [VAL_W-1:0] level_c, level_q;
  logic                    k_ok;
  logic [SORT_W-1:0]       k_idx;

  assign ca_sum = (VAL_W + 1)'(avg[0]) + (VAL_W + 1)'(avg[1]);
  assign k_ok   = (KC_W'(rank_q) >= KC_W'(1)) && (KC_W'(rank_q) <= (KC_W'(r_eff) << 1));
  assign k_idx  = SORT_W'(rank_q - 7'd1);

  always_comb begin
    case (mode_q)
      cfd_pkg::MODE_CA: level_c = VAL_W'(ca_sum >>> 1);
      cfd_pkg::MODE_SO: level_c = (avg[0] < avg[1]) ? avg[0] : avg[1];
      cfd_pkg::MODE_GO: level_c = (avg[0] > avg[1]) ? avg[0] : avg[1];
      cfd_pkg::MODE_OS: level_c = k_ok ? sorted_q[k_idx] : '0;
      default:          level_c = '0;
    endcase
  end

  logic signed [PROD_W-1:0]           prod_q;
  logic [cfd_pkg::SAMPLE_W-1:0]       smp_q;

  always_ff @(posedge clk_i) begin
    if (start) begin
      sum_q[0] <= '0;
      sum_q[1] <= '0;
      cnt_q    <= '0;
    end else if (take_q) begin
      sum_q[side_q] <= sum_q[side_q] + SUM_W'(cell_v);
      sorted_q      <= ins_v;
      cnt_q         <= cnt_q + (SORT_W + 1)'(1);
    end
    if (state_q == cfd_pkg::ST_SMP) begin
      smp_q <= mem_rd_q;
    end
    for (int l = 0; l < 2; l++) begin
      if (div_load) begin
        neg_q[l] <= sum_q[l][SUM_W-1];
        dq_q[l]  <= sum_q[l][SUM_W-1] ? SUM_W'(-sum_q[l]) : SUM_W'(sum_q[l]);
        rem_q[l] <= '0;
      end else if (div_step) begin
        rem_q[l] <= ge[l] ? RW'(trial[l] - (RW + 1)'(r_eff)) : RW'(trial[l]);
        dq_q[l]  <= {dq_q[l][SUM_W-2:0], ge[l]};
      end
    end
    if (state_q == cfd_pkg::ST_LEVEL) begin
      level_q <= level_c;
    end
    if (state_q == cfd_pkg::ST_MUL) begin
      prod_q <= $signed({1'b0, scale_q}) * level_q;
    end
  end

  // threshold and result
  logic signed [THR_W-1:0] thr;
  logic signed [THR_W-1:0] smp_ext;

  assign thr     = prod_q[PROD_W-1:8];
  assign smp_ext = THR_W'($signed(smp_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      cell_index_o <= cfd_pkg::CELL_INDEX_W'(cut_q);
      detection_o  <= (smp_ext > thr) ? $signed(smp_q) : '0;
      if (thr < 0) begin
        threshold_level_o <= '0;
      end else if (thr > THR_W'(cfd_pkg::LEVEL_MAX)) begin
        threshold_level_o <= cfd_pkg::LEVEL_W'(cfd_pkg::LEVEL_MAX);
      end else begin
        threshold_level_o <= cfd_pkg::LEVEL_W'(thr);
      end
      last_cell_o <= (cut_q == c_last);
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

/* rtl/core/cfd_checker.sv */
// Port checker of the CFAR frame detector, bound to its top level.
`include "cfar_frame_detector_unit_macros.svh"

module cfd_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_stall_o,
  input logic                              action_i,
  input logic                              out_valid_o,
  input logic                              out_stall_i,
  input logic [cfd_pkg::CELL_INDEX_W-1:0]  cell_index_o
);

  `CFD_ASSERT_RST(a_reset_stall, !rst_ni |-> in_stall_o, "input not stalled during reset")
  `CFD_ASSERT(a_emit_busy, in_valid_i && !in_stall_o && action_i |=> in_stall_o, "emit transfer did not stall input")
  `CFD_ASSERT(a_load_free, in_valid_i && !in_stall_o && !action_i |=> !in_stall_o, "load transfer stalled input")
  `CFD_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(cell_index_o), "stalled result dropped or changed")

endmodule

bind cfar_frame_detector_unit cfd_checker u_cfd_checker (.*);
